FILE: hw/rtl/drpi_pkg.sv
// Shared types, constants and tables of the dead-reckoning position integrator.
`default_nettype none
package drpi_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int POS_BITS_DEF     = 48;

    localparam logic [1:0] CFG_SILENCE = 2'd0;
    localparam logic [1:0] CFG_STALE   = 2'd1;
    localparam logic [1:0] CFG_SOURCE  = 2'd2;

    localparam logic [15:0] SILENCE_RESET = 16'd1000;
    localparam logic [15:0] STALE_RESET   = 16'd200;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DECIDE,
        ST_A_MX,
        ST_A_UX,
        ST_A_UY,
        ST_V_CORD,
        ST_V_M1,
        ST_V_M2,
        ST_V_M3,
        ST_V_M4,
        ST_V_M5,
        ST_V_S1,
        ST_V_S2,
        ST_P_MN,
        ST_P_SN,
        ST_P_WN,
        ST_P_ME,
        ST_P_SE,
        ST_P_WE,
        ST_DONE
    } drpi_state_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/drpi_cordic.sv
// Iterative CORDIC rotation giving cosine and sine of a heading in Q30.
`default_nettype none
module drpi_cordic
    import drpi_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [15:0]        heading,
    output logic                    done,
    output logic signed [31:0]      cos_q30,
    output logic signed [31:0]      sin_q30
);
    localparam int CW = $clog2(CORDIC_STEPS + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              flip_reg, flip_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [31:0]       ang;
    logic signed [33:0] z0, atan_v;

    assign ang    = {heading, 16'd0};
    assign z0     = 34'(signed'(ang));
    assign atan_v = 34'(atan_turn(5'(cnt_reg)));

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        flip_next = flip_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = CORDIC_X0;
            y_next    = '0;
            if (z0 > 34'sd1073741824 || z0 < -34'sd1073741824) begin
                flip_next = 1'b1;
                z_next    = 34'(signed'(ang - 32'h8000_0000));
            end else begin
                flip_next = 1'b0;
                z_next    = z0;
            end
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_next = x_reg - (y_reg >>> cnt_reg);
                y_next = y_reg + (x_reg >>> cnt_reg);
                z_next = z_reg - atan_v;
            end else begin
                x_next = x_reg + (y_reg >>> cnt_reg);
                y_next = y_reg - (x_reg >>> cnt_reg);
                z_next = z_reg + atan_v;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        flip_reg <= flip_next;
        cnt_reg  <= cnt_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign done    = done_reg;
    assign cos_q30 = flip_reg ? 32'(-x_reg) : 32'(x_reg);
    assign sin_q30 = flip_reg ? 32'(-y_reg) : 32'(y_reg);

endmodule
`default_nettype wire

FILE: hw/rtl/drpi_div1000.sv
// Signed division by one thousand, rounding half away from zero, one 16-bit digit a cycle.
`default_nettype none
module drpi_div1000 (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [63:0] dividend,
    output logic                    busy,
    output logic                    done,
    output logic signed [63:0]      quotient
);
    localparam logic [26:0] RECIP_1000 = 27'd68719477;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        neg_reg, neg_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] mag;
    logic [25:0] part;
    logic [52:0] recip;
    logic [15:0] digit;

    assign mag   = dividend[63] ? 64'(-dividend) : 64'(dividend);
    assign part  = {rem_reg, 16'd0} + 26'(q_reg[63:48]);
    assign recip = {27'd0, part} * {26'd0, RECIP_1000};
    assign digit = recip[51:36];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start) begin
            busy_next = 1'b1;
            neg_next  = dividend[63];
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = mag + 64'd500;
        end else if (busy_reg) begin
            rem_next = 10'(part - 26'(digit) * 26'd1000);
            q_next   = {q_reg[47:0], digit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule
`default_nettype wire

FILE: hw/rtl/dead_reckoning_position_integrator_core.sv
// Top level of the dead-reckoning position integrator: sequencer, state and shared multiplier.
`default_nettype none
// Each poll is one input transaction and gives one result transaction. The block takes a
// poll only when its sequencer is idle and works on it alone. The time from one accepted
// poll to the next depends on the path (fatal, rejected or no sample, accelerometer update
// or velocity update) and is set by the CORDIC unit at one iteration per cycle, by the
// single 32 by 32 multiplier that is shared by all products, by the divider by one
// thousand, which runs once for each of the two position steps, and by an output register
// that still holds an untaken result. A finished result waits in that output register, so a
// new poll may be accepted before it is taken. Configuration writes are always accepted and
// are meant to arrive only while the block is idle.
module dead_reckoning_position_integrator_core
    import drpi_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int POS_BITS     = POS_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [31:0]        s_now_ms,
    input  wire logic               s_acc_ready,
    input  wire logic [31:0]        s_acc_time_ms,
    input  wire logic signed [15:0] s_acc_x,
    input  wire logic signed [15:0] s_acc_y,
    input  wire logic               s_heading_ready,
    input  wire logic [31:0]        s_heading_time_ms,
    input  wire logic [15:0]        s_heading,
    input  wire logic               s_vel_ready,
    input  wire logic [31:0]        s_vel_time_ms,
    input  wire logic signed [15:0] s_vel_forward,
    input  wire logic signed [15:0] s_vel_right,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [47:0]      m_pos_north,
    output logic signed [47:0]      m_pos_east,
    output logic                    m_updated,
    output logic                    m_stale_rejected,
    output logic                    m_active_source,
    output logic                    m_fatal
);
    drpi_state_t state_reg, state_next;

    logic [31:0] now_reg, acc_t_reg, hd_t_reg, vl_t_reg;
    logic        acc_rdy_reg, hd_rdy_reg, vl_rdy_reg;
    logic signed [15:0] ax_reg, ay_reg, vf_reg, vr_reg;
    logic [15:0] hd_reg;

    logic [15:0] silence_reg, silence_next, stale_reg, stale_next;
    logic        init_src_reg, init_src_next;

    logic signed [POS_BITS-1:0] north_reg, north_next, east_reg, east_next;
    logic signed [31:0] velx_reg, velx_next, vely_reg, vely_next;
    logic [31:0] prev_reg, prev_next, good_reg, good_next;
    logic        have_prev_reg, have_prev_next, src_reg, src_next;
    logic        switched_reg, switched_next, fatal_reg, fatal_next;

    logic signed [31:0] dt_reg, dt_next, vn_reg, vn_next, ve_reg, ve_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [47:0] sum1_reg, sum1_next, sum2_reg, sum2_next;
    logic        upd_reg, upd_next, stl_reg, stl_next;

    logic        mv_reg, mv_next;
    logic signed [47:0] mo_n_reg, mo_n_next, mo_e_reg, mo_e_next;
    logic        mo_u_reg, mo_u_next, mo_s_reg, mo_s_next;
    logic        mo_src_reg, mo_src_next, mo_f_reg, mo_f_next;

    logic signed [31:0] mul_a, mul_b;
    logic        cord_start, cord_done, div_start, div_busy, div_done;
    logic signed [31:0] cos_v, sin_v;
    logic signed [63:0] quo;

    logic signed [32:0] d_silence, d_acc, d_hd, d_vl;
    logic signed [32:0] lim_silence, lim_stale;
    logic signed [63:0] vel_wide;
    logic signed [65:0] pos_sum, pos_hi, pos_lo, pos_base;
    logic signed [POS_BITS-1:0] pos_sat;
    logic signed [63:0] scale_in, scaled;
    logic signed [31:0] pos_rate;

    drpi_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .heading (hd_reg),
        .done    (cord_done),
        .cos_q30 (cos_v),
        .sin_q30 (sin_v)
    );

    drpi_div1000 u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo)
    );

    assign d_silence = 33'(signed'(now_reg - good_reg));
    assign d_acc     = 33'(signed'(now_reg - acc_t_reg));
    assign d_hd      = 33'(signed'(now_reg - hd_t_reg));
    assign d_vl      = 33'(signed'(now_reg - vl_t_reg));

    assign lim_silence = $signed({17'd0, silence_reg});
    assign lim_stale   = $signed({17'd0, stale_reg});

    assign pos_hi   = (66'sd1 <<< (POS_BITS - 1)) - 66'sd1;
    assign pos_lo   = -pos_hi - 66'sd1;
    assign pos_base = (state_reg == ST_P_WE) ? 66'(east_reg) : 66'(north_reg);
    assign pos_sum  = pos_base + 66'(quo);
    assign pos_sat  = (pos_sum > pos_hi) ? POS_BITS'(pos_hi) :
                      (pos_sum < pos_lo) ? POS_BITS'(pos_lo) : POS_BITS'(pos_sum);

    assign scale_in = (state_reg == ST_V_S2) ? 64'(sum2_reg) : 64'(sum1_reg);
    assign scaled   = (scale_in <<< 10) - (scale_in <<< 4) - (scale_in <<< 3)
                      + 64'sd536870912;

    assign pos_rate = (state_reg == ST_P_MN) ? (src_reg ? vn_reg : velx_reg)
                                             : (src_reg ? ve_reg : vely_reg);

    always_comb begin
        case (state_reg)
            ST_A_MX: begin mul_a = 32'(ax_reg); mul_b = dt_reg; end
            ST_A_UX: begin mul_a = 32'(ay_reg); mul_b = dt_reg; end
            ST_V_M1: begin mul_a = 32'(vf_reg); mul_b = cos_v;  end
            ST_V_M2: begin mul_a = 32'(vr_reg); mul_b = sin_v;  end
            ST_V_M3: begin mul_a = 32'(vf_reg); mul_b = sin_v;  end
            ST_V_M4: begin mul_a = 32'(vr_reg); mul_b = cos_v;  end
            default: begin mul_a = dt_reg;      mul_b = pos_rate; end
        endcase
    end

    assign prod_next = 64'(mul_a) * 64'(mul_b);
    assign vel_wide  = (state_reg == ST_A_UX) ? 64'(velx_reg) + prod_reg
                                              : 64'(vely_reg) + prod_reg;

    always_comb begin
        state_next     = state_reg;
        silence_next   = silence_reg;
        stale_next     = stale_reg;
        init_src_next  = init_src_reg;
        north_next     = north_reg;
        east_next      = east_reg;
        velx_next      = velx_reg;
        vely_next      = vely_reg;
        prev_next      = prev_reg;
        good_next      = good_reg;
        have_prev_next = have_prev_reg;
        src_next       = src_reg;
        switched_next  = switched_reg;
        fatal_next     = fatal_reg;
        dt_next        = dt_reg;
        vn_next        = vn_reg;
        ve_next        = ve_reg;
        sum1_next      = sum1_reg;
        sum2_next      = sum2_reg;
        upd_next       = upd_reg;
        stl_next       = stl_reg;
        mv_next        = mv_reg && !m_ready;
        mo_n_next      = mo_n_reg;
        mo_e_next      = mo_e_reg;
        mo_u_next      = mo_u_reg;
        mo_s_next      = mo_s_reg;
        mo_src_next    = mo_src_reg;
        mo_f_next      = mo_f_reg;
        cord_start     = 1'b0;
        div_start      = 1'b0;
        s_ready        = (state_reg == ST_IDLE);
        cfg_ready      = 1'b1;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_SILENCE: silence_next = cfg_data;
                CFG_STALE:   stale_next   = cfg_data;
                CFG_SOURCE: begin
                    init_src_next = cfg_data[0];
                    if (!switched_reg) begin
                        src_next = cfg_data[0];
                    end
                end
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    upd_next   = 1'b0;
                    stl_next   = 1'b0;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (fatal_reg) begin
                    state_next = ST_DONE;
                end else if (d_silence > lim_silence) begin
                    if (switched_reg) begin
                        fatal_next = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        switched_next  = 1'b1;
                        src_next       = !src_reg;
                        north_next     = '0;
                        east_next      = '0;
                        velx_next      = '0;
                        vely_next      = '0;
                        prev_next      = '0;
                        have_prev_next = 1'b0;
                        good_next      = now_reg;
                        state_next     = ST_DECIDE;
                    end
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = ST_DONE;
                if (!src_reg && acc_rdy_reg) begin
                    if (d_acc > lim_stale) begin
                        stl_next = 1'b1;
                    end else begin
                        dt_next        = signed'(acc_t_reg - (have_prev_reg ? prev_reg : now_reg));
                        prev_next      = acc_t_reg;
                        have_prev_next = 1'b1;
                        good_next      = now_reg;
                        upd_next       = 1'b1;
                        state_next     = ST_A_MX;
                    end
                end else if (src_reg && vl_rdy_reg && hd_rdy_reg) begin
                    if (d_vl > lim_stale || d_hd > lim_stale) begin
                        stl_next = 1'b1;
                    end else begin
                        dt_next        = signed'(now_reg - (have_prev_reg ? prev_reg : now_reg));
                        prev_next      = now_reg;
                        have_prev_next = 1'b1;
                        good_next      = now_reg;
                        upd_next       = 1'b1;
                        cord_start     = 1'b1;
                        state_next     = ST_V_CORD;
                    end
                end
            end
            ST_A_MX: state_next = ST_A_UX;
            ST_A_UX: begin
                velx_next  = (vel_wide > 64'sd2147483647) ? 32'sh7fff_ffff :
                             (vel_wide < -64'sd2147483648) ? 32'sh8000_0000 : 32'(vel_wide);
                state_next = ST_A_UY;
            end
            ST_A_UY: begin
                vely_next  = (vel_wide > 64'sd2147483647) ? 32'sh7fff_ffff :
                             (vel_wide < -64'sd2147483648) ? 32'sh8000_0000 : 32'(vel_wide);
                state_next = ST_P_MN;
            end
            ST_V_CORD: begin
                if (cord_done) begin
                    state_next = ST_V_M1;
                end
            end
            ST_V_M1: state_next = ST_V_M2;
            ST_V_M2: begin
                sum1_next  = 48'(prod_reg);
                state_next = ST_V_M3;
            end
            ST_V_M3: begin
                sum1_next  = sum1_reg - 48'(prod_reg);
                state_next = ST_V_M4;
            end
            ST_V_M4: begin
                sum2_next  = 48'(prod_reg);
                state_next = ST_V_M5;
            end
            ST_V_M5: begin
                sum2_next  = sum2_reg + 48'(prod_reg);
                state_next = ST_V_S1;
            end
            ST_V_S1: begin
                vn_next    = scaled[61:30];
                state_next = ST_V_S2;
            end
            ST_V_S2: begin
                ve_next    = scaled[61:30];
                state_next = ST_P_MN;
            end
            ST_P_MN: state_next = ST_P_SN;
            ST_P_SN: begin
                div_start  = 1'b1;
                state_next = ST_P_WN;
            end
            ST_P_WN: begin
                if (div_done) begin
                    north_next = pos_sat;
                    state_next = ST_P_ME;
                end
            end
            ST_P_ME: state_next = ST_P_SE;
            ST_P_SE: begin
                div_start  = 1'b1;
                state_next = ST_P_WE;
            end
            ST_P_WE: begin
                if (div_done) begin
                    east_next  = pos_sat;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next     = 1'b1;
                    mo_n_next   = 48'(64'(north_reg));
                    mo_e_next   = 48'(64'(east_reg));
                    mo_u_next   = upd_reg;
                    mo_s_next   = stl_reg;
                    mo_src_next = src_reg;
                    mo_f_next   = fatal_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            silence_reg   <= SILENCE_RESET;
            stale_reg     <= STALE_RESET;
            init_src_reg  <= 1'b0;
            north_reg     <= '0;
            east_reg      <= '0;
            velx_reg      <= '0;
            vely_reg      <= '0;
            prev_reg      <= '0;
            good_reg      <= '0;
            have_prev_reg <= 1'b0;
            src_reg       <= 1'b0;
            switched_reg  <= 1'b0;
            fatal_reg     <= 1'b0;
            mv_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            silence_reg   <= silence_next;
            stale_reg     <= stale_next;
            init_src_reg  <= init_src_next;
            north_reg     <= north_next;
            east_reg      <= east_next;
            velx_reg      <= velx_next;
            vely_reg      <= vely_next;
            prev_reg      <= prev_next;
            good_reg      <= good_next;
            have_prev_reg <= have_prev_next;
            src_reg       <= src_next;
            switched_reg  <= switched_next;
            fatal_reg     <= fatal_next;
            mv_reg        <= mv_next;
        end
        if (s_valid && s_ready) begin
            now_reg     <= s_now_ms;
            acc_rdy_reg <= s_acc_ready;
            acc_t_reg   <= s_acc_time_ms;
            ax_reg      <= s_acc_x;
            ay_reg      <= s_acc_y;
            hd_rdy_reg  <= s_heading_ready;
            hd_t_reg    <= s_heading_time_ms;
            hd_reg      <= s_heading;
            vl_rdy_reg  <= s_vel_ready;
            vl_t_reg    <= s_vel_time_ms;
            vf_reg      <= s_vel_forward;
            vr_reg      <= s_vel_right;
        end
        dt_reg     <= dt_next;
        vn_reg     <= vn_next;
        ve_reg     <= ve_next;
        prod_reg   <= prod_next;
        sum1_reg   <= sum1_next;
        sum2_reg   <= sum2_next;
        upd_reg    <= upd_next;
        stl_reg    <= stl_next;
        mo_n_reg   <= mo_n_next;
        mo_e_reg   <= mo_e_next;
        mo_u_reg   <= mo_u_next;
        mo_s_reg   <= mo_s_next;
        mo_src_reg <= mo_src_next;
        mo_f_reg   <= mo_f_next;
    end

    assign m_valid          = mv_reg;
    assign m_pos_north      = mo_n_reg;
    assign m_pos_east       = mo_e_reg;
    assign m_updated        = mo_u_reg;
    assign m_stale_rejected = mo_s_reg;
    assign m_active_source  = mo_src_reg;
    assign m_fatal          = mo_f_reg;

    // The fatal flag and the source switch are sticky until reset.
    a_fatal_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        fatal_reg |=> fatal_reg) else $error("fatal flag cleared");

    a_switch_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        switched_reg |=> switched_reg) else $error("switch flag cleared");

    // A fatal poll needs an earlier switch.
    a_fatal_after_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        fatal_reg |-> switched_reg) else $error("fatal without a switch");

    a_result_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_updated && m_stale_rejected)) else $error("updated and stale both set");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy) else $error("divider restarted while busy");

endmodule
`default_nettype wire
